### design/gbuf_pkg.sv
// shared constants, codes and tables for the grid barrier union-find block
package gbuf_pkg;

	localparam int RANK_W = 4;
	localparam int DAY_W  = 12;
	localparam int CFG_W  = 7;
	localparam int CELL_W = 6;

	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
	localparam logic [DAY_W-1:0]  DAY_MAX  = 12'd4095;

	// register indexes on the config channel
	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	// step codes of the per-cell sequence; 0..7 are the neighbors
	localparam logic [3:0] STEP_LEFT  = 4'd8;
	localparam logic [3:0] STEP_RIGHT = 4'd9;
	localparam logic [3:0] STEP_CHECK = 4'd10;

	// row offset of neighbor k
	function automatic logic signed [1:0] nbr_dr(input logic [2:0] k);
		logic signed [1:0] d;
		unique case (k)
			3'd0, 3'd1, 3'd2: d = -2'sd1;
			3'd3, 3'd4:       d = 2'sd0;
			default:          d = 2'sd1;
		endcase
		return d;
	endfunction

	// column offset of neighbor k
	function automatic logic signed [1:0] nbr_dc(input logic [2:0] k);
		logic signed [1:0] d;
		unique case (k)
			3'd0, 3'd3, 3'd5: d = -2'sd1;
			3'd1, 3'd6:       d = 2'sd0;
			default:          d = 2'sd1;
		endcase
		return d;
	endfunction

endpackage

### design/gbuf_mem.sv
// node memory: flooded bit, rank and parent per node, one port, registered read
module gbuf_mem #(
	parameter int AW = 13,
	parameter int DW = 18,
	parameter int DEPTH = 4098
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

### design/gbuf_seq.sv
// sequencer: clear sweep, mark, neighbor unions by rank, root walks, result beat
module gbuf_seq #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int NODES = MAX_ROWS * MAX_COLS + 2,
	parameter int AW = $clog2(NODES),
	parameter int DW = AW + gbuf_pkg::RANK_W + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [gbuf_pkg::CELL_W-1:0]    in_row,
	input  logic [gbuf_pkg::CELL_W-1:0]    in_col,
	input  logic                           in_new,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gbuf_pkg::DAY_W-1:0]     out_day,
	output logic                           out_blocked,
	input  logic                           cfg_valid,
	input  logic                           cfg_index,
	input  logic [gbuf_pkg::CFG_W-1:0]     cfg_data,
	output logic                           mem_we,
	output logic [AW-1:0]                  mem_addr,
	output logic [DW-1:0]                  mem_wdata,
	input  logic [DW-1:0]                  mem_rdata
);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b000000000001,
		S_CLR      = 12'b000000000010,
		S_START    = 12'b000000000100,
		S_MARK_RD  = 12'b000000001000,
		S_MARK_WR  = 12'b000000010000,
		S_STEP     = 12'b000000100000,
		S_NB_RD    = 12'b000001000000,
		S_NB_CHK   = 12'b000010000000,
		S_FIND_RD  = 12'b000100000000,
		S_FIND_CHK = 12'b001000000000,
		S_LINK     = 12'b010000000000,
		S_BUMP     = 12'b100000000000
	} state_t;

	localparam logic [AW-1:0] LEFT_NODE  = AW'(0);
	localparam logic [AW-1:0] RIGHT_NODE = AW'(1);
	localparam logic [AW-1:0] LAST_NODE  = AW'(NODES - 1);

	state_t st_q;
	logic [AW-1:0] clr_q, cur_q, node_q, nb_q, ra_q;
	logic [gbuf_pkg::RANK_W-1:0] rka_q;
	logic fa_q, fb_q, phase_q, blocked_q, out_valid_q, out_blocked_q, done_q;
	logic [3:0] step_q;
	logic [gbuf_pkg::CELL_W-1:0] row_q, col_q;
	logic [gbuf_pkg::CFG_W-1:0] rows_q, cols_q;
	logic [gbuf_pkg::DAY_W-1:0] day_q, out_day_q;

	logic [8:0] rows_eff, cols_eff;
	logic signed [9:0] nr, nc;
	logic nb_ok, in_grid;
	logic [AW-1:0] cell_node, nbr_node;
	logic rd_flood;
	logic [gbuf_pkg::RANK_W-1:0] rd_rank;
	logic [AW-1:0] rd_parent;
	logic load_out;

	assign rd_flood  = mem_rdata[DW-1];
	assign rd_rank   = mem_rdata[AW +: gbuf_pkg::RANK_W];
	assign rd_parent = mem_rdata[AW-1:0];

	assign rows_eff = ({2'b0, rows_q} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {2'b0, rows_q};
	assign cols_eff = ({2'b0, cols_q} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {2'b0, cols_q};
	assign in_grid  = ({3'b0, row_q} < rows_eff) && ({3'b0, col_q} < cols_eff);

	assign nr = signed'({4'b0, row_q}) + 10'(gbuf_pkg::nbr_dr(step_q[2:0]));
	assign nc = signed'({4'b0, col_q}) + 10'(gbuf_pkg::nbr_dc(step_q[2:0]));
	assign nb_ok = !nr[9] && !nc[9] && (nr < signed'({1'b0, rows_eff}))
		&& (nc < signed'({1'b0, cols_eff}));
	assign cell_node = AW'(32'(row_q) * MAX_COLS + 32'(col_q) + 2);
	assign nbr_node  = AW'(32'(nr[8:0]) * MAX_COLS + 32'(nc[8:0]) + 2);

	// final check done and the output register free this cycle
	assign load_out = (st_q == S_LINK) && (step_q == gbuf_pkg::STEP_CHECK)
		&& (!out_valid_q || out_ready);

	assign in_ready    = (st_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign out_day     = out_day_q;
	assign out_blocked = out_blocked_q;

	// memory port mux
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = cur_q;
		mem_wdata = {1'b0, gbuf_pkg::RANK_W'(0), clr_q};
		unique case (st_q)
			S_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_MARK_RD: mem_addr = node_q;
			S_MARK_WR: begin
				mem_we    = 1'b1;
				mem_addr  = node_q;
				mem_wdata = {1'b1, rd_rank, rd_parent};
			end
			S_NB_RD: mem_addr = nb_q;
			S_LINK: begin
				if (step_q != gbuf_pkg::STEP_CHECK && ra_q != cur_q) begin
					mem_we = 1'b1;
					if (rka_q <= rd_rank) begin
						mem_addr  = ra_q;
						mem_wdata = {fa_q, rka_q, cur_q};
					end else begin
						mem_addr  = cur_q;
						mem_wdata = {rd_flood, rd_rank, ra_q};
					end
				end
			end
			S_BUMP: begin
				// ranks were equal, so the new root rank is rka_q + 1
				mem_we    = 1'b1;
				mem_addr  = cur_q;
				mem_wdata = {fb_q, rka_q + 1'b1, cur_q};
			end
			default: ;
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd64;
			cols_q <= 7'd64;
		end else if (cfg_valid) begin
			if (cfg_index == gbuf_pkg::REG_GRID_ROWS) rows_q <= cfg_data;
			else cols_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLR;
			clr_q       <= '0;
			done_q      <= 1'b0;
			step_q      <= '0;
			phase_q     <= 1'b0;
			day_q       <= '0;
			blocked_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out) out_valid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						row_q  <= in_row;
						col_q  <= in_col;
						done_q <= 1'b1;
						if (in_new) begin
							day_q     <= '0;
							blocked_q <= 1'b0;
							clr_q     <= '0;
							st_q      <= S_CLR;
						end else begin
							st_q <= S_START;
						end
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_NODE) begin
						// after reset there is no item waiting
						st_q <= done_q ? S_START : S_IDLE;
					end
				end
				S_START: begin
					node_q <= cell_node;
					if (in_grid) begin
						step_q <= '0;
						st_q   <= S_MARK_RD;
					end else begin
						step_q <= gbuf_pkg::STEP_CHECK;
						ra_q   <= '0;
						cur_q  <= '1;
						st_q   <= S_LINK;
					end
				end
				S_MARK_RD: st_q <= S_MARK_WR;
				S_MARK_WR: st_q <= S_STEP;
				S_STEP: begin
					phase_q <= 1'b0;
					priority if (step_q == gbuf_pkg::STEP_CHECK) begin
						cur_q <= LEFT_NODE;
						nb_q  <= RIGHT_NODE;
						st_q  <= S_FIND_RD;
					end else if (step_q == gbuf_pkg::STEP_RIGHT) begin
						cur_q <= node_q;
						nb_q  <= RIGHT_NODE;
						if ({3'b0, col_q} + 9'd1 == cols_eff) st_q <= S_FIND_RD;
						else step_q <= step_q + 1'b1;
					end else if (step_q == gbuf_pkg::STEP_LEFT) begin
						cur_q <= node_q;
						nb_q  <= LEFT_NODE;
						if (col_q == '0) st_q <= S_FIND_RD;
						else step_q <= step_q + 1'b1;
					end else begin
						cur_q <= node_q;
						nb_q  <= nbr_node;
						if (nb_ok) st_q <= S_NB_RD;
						else step_q <= step_q + 1'b1;
					end
				end
				S_NB_RD: st_q <= S_NB_CHK;
				S_NB_CHK: begin
					if (rd_flood) begin
						st_q <= S_FIND_RD;
					end else begin
						step_q <= step_q + 1'b1;
						st_q   <= S_STEP;
					end
				end
				S_FIND_RD: st_q <= S_FIND_CHK;
				S_FIND_CHK: begin
					if (rd_parent != cur_q) begin
						cur_q <= rd_parent;
						st_q  <= S_FIND_RD;
					end else if (!phase_q) begin
						ra_q    <= cur_q;
						rka_q   <= rd_rank;
						fa_q    <= rd_flood;
						phase_q <= 1'b1;
						cur_q   <= nb_q;
						st_q    <= S_FIND_RD;
					end else begin
						// root of b stays in cur_q, its entry on the read port
						st_q <= S_LINK;
					end
				end
				S_LINK: begin
					if (step_q == gbuf_pkg::STEP_CHECK) begin
						if (in_grid && ra_q == cur_q) blocked_q <= 1'b1;
						if (!out_valid_q || out_ready) begin
							out_valid_q   <= 1'b1;
							out_day_q     <= day_q;
							out_blocked_q <= blocked_q || (in_grid && ra_q == cur_q);
							day_q         <= (day_q == gbuf_pkg::DAY_MAX) ? day_q
								: day_q + 1'b1;
							done_q        <= 1'b0;
							st_q          <= S_IDLE;
						end
					end else if (ra_q != cur_q && rka_q == rd_rank
							&& rd_rank != gbuf_pkg::RANK_MAX) begin
						// keep the flooded bit of root b for the rank write
						fb_q <= rd_flood;
						st_q <= S_BUMP;
					end else begin
						step_q <= step_q + 1'b1;
						st_q   <= S_STEP;
					end
				end
				S_BUMP: begin
					step_q <= step_q + 1'b1;
					st_q   <= S_STEP;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

### design/grid_barrier_union_find_top.sv
// top level of the grid barrier union-find block
//
// channel | dir | handshake             | payload
// s_axis  | in  | s_axis_tvalid/tready  | tdata: cell_row, cell_col; tuser: new_grid
// m_axis  | out | m_axis_tvalid/tready  | tdata: day_index, blocked
// cfg     | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data (grid_rows, grid_cols)
//
// one cell at a time, every step through the single memory port: the cell is
// marked by a read and a write, each in-range neighbor is read and checked,
// out-of-range neighbors and skipped edge steps cost no read, each union walks
// both roots by parent hops and links them (with a rank bump on equal ranks),
// the final edge check walks both edge roots, then idle takes the next beat
// reset and every new_grid beat run a clearing pass over all MAX_ROWS*MAX_COLS+2
// nodes of the node memory before the cell is processed
// the result sits in an output register, so the next cell is taken while
// the last result waits on m_axis_tready
// config writes are always taken (cfg_ready is tied high)
module grid_barrier_union_find_top #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [5:0] cell_row, [11:6] cell_col, rest zero
	input  logic        s_axis_tuser,  // [0] new_grid
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [11:0] day_index, [12] blocked, rest zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int NODES = MAX_ROWS * MAX_COLS + 2;
	localparam int AW = $clog2(NODES);
	localparam int DW = AW + gbuf_pkg::RANK_W + 1;

	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [DW-1:0] mem_wdata, mem_rdata;
	logic [gbuf_pkg::DAY_W-1:0] day;
	logic          blk;

	assign cfg_ready = 1'b1;

	// node memory: node 0 left edge, node 1 right edge, then cells row-major
	gbuf_mem #(.AW(AW), .DW(DW), .DEPTH(NODES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	gbuf_seq #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_row      (s_axis_tdata[5:0]),
		.in_col      (s_axis_tdata[11:6]),
		.in_new      (s_axis_tuser),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_day     (day),
		.out_blocked (blk),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mem_we      (mem_we),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata)
	);

	assign m_axis_tdata = {3'b0, blk, day};

endmodule

### design/gbuf_checker.sv
// port-level checker for the grid barrier union-find block, with its bind
module gbuf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed under stall");

	// one cell at a time: busy right after a beat is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while busy");

	// a new result only appears once a cell has been in work
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without a cell in work");

	// a result taken with a new-grid beat leaves no stale result behind
	a_new_day: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && s_axis_tvalid && s_axis_tready && s_axis_tuser
		|=> !m_axis_tvalid)
		else $error("stale result after new grid");

endmodule

bind grid_barrier_union_find_top gbuf_checker u_chk (.*);
